/* rtl/core/rsc_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Rabbit stream cipher package
// Shared types and constants for the Rabbit keystream core.
// ----------------------------------------------------------------------------
package rsc_pkg;

    localparam int unsigned WordW = 32;
    localparam int unsigned NumWords = 8;

    typedef logic [WordW-1:0] word_t;

    typedef enum logic [1:0] {
        CFG_KEY_LOW  = 2'd0,
        CFG_KEY_HIGH = 2'd1,
        CFG_IV       = 2'd2,
        CFG_USE_IV   = 2'd3
    } cfg_idx_t;

    // The three counter constants repeat over the eight counter words.
    function automatic word_t add_const(input logic [2:0] idx);
        word_t r;
        unique case (idx)
            3'd0, 3'd3, 3'd6: r = 32'h4D34D34D;
            3'd1, 3'd4, 3'd7: r = 32'hD34D34D3;
            default:          r = 32'h34D34D34;
        endcase
        return r;
    endfunction

    function automatic word_t rotl16(input word_t v);
        return {v[15:0], v[31:16]};
    endfunction

    function automatic word_t rotl8(input word_t v);
        return {v[23:0], v[31:24]};
    endfunction

endpackage

/* rtl/core/rabbit_stream_cipher.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Rabbit stream cipher core
// Byte-wide Rabbit (RFC 4503) keystream engine with key and IV setup.
// ----------------------------------------------------------------------------
// Usage: configure key_low, key_high, iv_value and use_iv through the write
// port while idle. A transfer on the s_ channel with s_mode = 1 restarts the
// cipher: key setup (four state updates and a counter re-key) and, when use_iv
// is set, IV setup (four more updates). A restart produces no output transfer.
// A transfer with s_mode = 0 yields one m_ transfer carrying s_data_byte XOR
// the next keystream byte. s_last_of_call drops the rest of the current block.
// Inner and counter words live in two 8x32 synchronous memories. One state
// update walks the eight words: a counter pass, a g pass (one g-function per
// cycle, a 32x32 squaring registered before the fold) and a write-back pass.
// A data byte from a full buffer passes through the output state into the
// output register, and the next input is taken once that byte has left m_;
// a byte that needs a fresh block first runs one state update and the
// keystream extraction pass. A restart runs a load pass, four updates and a
// re-key pass; with use_iv set, an IV pass and four more updates follow.
// After reset a clearing pass zeroes both memories, so the state is zero and
// the buffer is empty, matching an unkeyed cipher; s_ready stays low until
// it ends. A stalled receiver holds the output register; no new input is
// taken until it drains.
// ----------------------------------------------------------------------------
module rabbit_stream_cipher
    import rsc_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [63:0] cfg_data,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic        s_mode,
    input  logic [7:0]  s_data_byte,
    input  logic        s_last_of_call,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [7:0]  m_out_byte
);

    typedef enum logic [8:0] {
        ST_IDLE  = 9'b000000001,
        ST_LOAD  = 9'b000000010,
        ST_CTR   = 9'b000000100,
        ST_GRD   = 9'b000001000,
        ST_GMUL  = 9'b000010000,
        ST_WB    = 9'b000100000,
        ST_REKEY = 9'b001000000,
        ST_KS    = 9'b010000000,
        ST_OUT   = 9'b100000000
    } state_t;

    state_t      state_reg, state_next;
    logic [63:0] key_low_reg, key_high_reg, iv_reg;
    logic        use_iv_reg;

    // State memories.
    word_t       x_mem [NumWords];
    word_t       c_mem [NumWords];
    word_t       x_rd, c_rd;
    logic [2:0]  x_ra, c_ra;
    logic        x_we, c_we;
    logic [2:0]  x_wa, c_wa;
    word_t       x_wd, c_wd;

    // Sequencer.
    logic [3:0]  idx_reg;          // word counter, 0..8
    logic [3:0]  iter_reg;         // remaining updates
    logic        iv_pend_reg;      // IV setup still due after re-key
    logic        rekey_done_reg;
    logic        make_ks_reg;      // update was for a keystream block
    logic        mem_clr_reg;      // load pass writes zeros after reset
    logic        carry_reg;
    word_t       g_reg [NumWords];
    logic [63:0] sq_reg;
    logic        sq_vld_reg;
    logic [2:0]  sq_idx_reg;
    logic        rd_vld_reg;
    logic [2:0]  rd_idx_reg;
    logic [7:0]  ks_reg [16];
    logic [4:0]  pos_reg;
    logic [7:0]  data_reg;
    logic        last_reg;
    logic [7:0]  out_reg;
    logic        m_valid_reg;

    // Key setup word placement (RFC 4503 layout).
    word_t k0, k1, k2, k3;
    word_t i0, i1, i2, i3;
    word_t load_x, load_c;
    assign k0 = key_low_reg[31:0];
    assign k1 = key_low_reg[63:32];
    assign k2 = key_high_reg[31:0];
    assign k3 = key_high_reg[63:32];
    assign i0 = iv_reg[31:0];
    assign i2 = iv_reg[63:32];
    assign i1 = {i2[31:16], i0[31:16]};
    assign i3 = {i2[15:0], i0[15:0]};

    always_comb begin
        unique case (idx_reg[2:0])
            3'd0: begin load_x = k0; load_c = rotl16(k2); end
            3'd1: begin load_x = {k3[15:0], k2[31:16]}; load_c = {k0[31:16], k1[15:0]}; end
            3'd2: begin load_x = k1; load_c = rotl16(k3); end
            3'd3: begin load_x = {k0[15:0], k3[31:16]}; load_c = {k1[31:16], k2[15:0]}; end
            3'd4: begin load_x = k2; load_c = rotl16(k0); end
            3'd5: begin load_x = {k1[15:0], k0[31:16]}; load_c = {k2[31:16], k3[15:0]}; end
            3'd6: begin load_x = k3; load_c = rotl16(k1); end
            default: begin load_x = {k2[15:0], k1[31:16]}; load_c = {k3[31:16], k0[15:0]}; end
        endcase
    end

    // IV word matching the delayed write index.
    word_t iv_word_d;
    always_comb begin
        unique case (rd_idx_reg[1:0])
            2'd0:    iv_word_d = i0;
            2'd1:    iv_word_d = i1;
            2'd2:    iv_word_d = i2;
            default: iv_word_d = i3;
        endcase
    end

    // Counter step: one word per cycle, carry kept in a register.
    logic [32:0] ctr_sum;
    assign ctr_sum = {1'b0, c_rd} + {1'b0, add_const(rd_idx_reg)} + {32'd0, carry_reg};

    // Next inner word for the write-back pass.
    word_t new_x;
    logic [2:0] wi;
    assign wi = idx_reg[2:0];
    always_comb begin
        if (wi[0] == 1'b0) begin
            new_x = g_reg[wi] + rotl16(g_reg[wi - 3'd1]) + rotl16(g_reg[wi - 3'd2]);
        end else begin
            new_x = g_reg[wi] + rotl8(g_reg[wi - 3'd1]) + g_reg[wi - 3'd2];
        end
    end

    // Keystream extraction reads x words in order; keep the stream in regs.
    word_t xs [NumWords];
    word_t s0, s1, s2, s3;
    assign s0 = xs[0] ^ {16'd0, xs[5][31:16]} ^ {xs[3][15:0], 16'd0};
    assign s1 = xs[2] ^ {16'd0, xs[7][31:16]} ^ {xs[5][15:0], 16'd0};
    assign s2 = xs[4] ^ {16'd0, xs[1][31:16]} ^ {xs[7][15:0], 16'd0};
    assign s3 = xs[6] ^ {16'd0, xs[3][31:16]} ^ {xs[1][15:0], 16'd0};

    always_ff @(posedge aclk) begin
        if (x_we) begin
            x_mem[x_wa] <= x_wd;
        end
        if (c_we) begin
            c_mem[c_wa] <= c_wd;
        end
        x_rd <= x_mem[x_ra];
        c_rd <= c_mem[c_ra];
    end

    // Memory access control.
    always_comb begin
        x_we = 1'b0;
        c_we = 1'b0;
        x_wa = idx_reg[2:0];
        c_wa = rd_idx_reg;
        x_wd = new_x;
        c_wd = ctr_sum[31:0];
        x_ra = idx_reg[2:0];
        c_ra = idx_reg[2:0];
        unique case (state_reg)
            ST_LOAD: begin
                x_we = ~idx_reg[3];
                c_we = ~idx_reg[3];
                c_wa = idx_reg[2:0];
                x_wd = mem_clr_reg ? '0 : load_x;
                c_wd = mem_clr_reg ? '0 : load_c;
            end
            ST_CTR: begin
                c_we = rd_vld_reg;
            end
            ST_GRD: begin
                // reads only
            end
            ST_WB: begin
                x_we = ~idx_reg[3];
            end
            ST_REKEY: begin
                // The key pass folds in x at idx+4; the IV pass folds in the IV.
                x_ra = idx_reg[2:0] + 3'd4;
                c_we = rd_vld_reg;
                c_wd = c_rd ^ (iv_pend_reg ? iv_word_d : x_rd);
            end
            ST_KS: begin
                // reads only
            end
            default: begin
            end
        endcase
    end

    logic [63:0] sq_comb;
    word_t       gsum;
    assign gsum = x_rd + c_rd;
    assign sq_comb = {32'd0, gsum} * {32'd0, gsum};

    logic in_fire, out_fire;
    assign s_ready  = (state_reg == ST_IDLE) && !m_valid_reg;
    assign in_fire  = s_valid && s_ready;
    assign out_fire = m_valid_reg && m_ready;
    assign m_valid  = m_valid_reg;
    assign m_out_byte = out_reg;

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (in_fire) begin
                    if (s_mode) begin
                        state_next = ST_LOAD;
                    end else if (pos_reg[4]) begin
                        state_next = ST_CTR;
                    end else begin
                        state_next = ST_OUT;
                    end
                end
            end
            ST_LOAD:  if (idx_reg[3]) state_next = mem_clr_reg ? ST_IDLE : ST_CTR;
            ST_CTR:   if (idx_reg[3] && !rd_vld_reg) state_next = ST_GRD;
            ST_GRD:   if (idx_reg[3] && !rd_vld_reg && !sq_vld_reg) state_next = ST_WB;
            ST_GMUL:  state_next = ST_WB;
            ST_WB: begin
                if (idx_reg[3]) begin
                    if (make_ks_reg) begin
                        state_next = ST_KS;
                    end else if (iter_reg != 4'd1) begin
                        state_next = ST_CTR;
                    end else if (!rekey_done_reg) begin
                        state_next = ST_REKEY;
                    end else begin
                        state_next = ST_IDLE;
                    end
                end
            end
            ST_REKEY: begin
                if (idx_reg[3] && !rd_vld_reg) begin
                    state_next = (!rekey_done_reg && use_iv_reg) ? ST_REKEY : ST_IDLE;
                    if (rekey_done_reg) state_next = ST_CTR;
                    else if (!use_iv_reg) state_next = ST_IDLE;
                end
            end
            ST_KS:    if (idx_reg[3] && !rd_vld_reg) state_next = ST_OUT;
            ST_OUT:   state_next = ST_IDLE;
            default:  state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_LOAD;
            key_low_reg    <= '0;
            key_high_reg   <= '0;
            iv_reg         <= '0;
            use_iv_reg     <= 1'b0;
            pos_reg        <= 5'd16;
            m_valid_reg    <= 1'b0;
            idx_reg        <= '0;
            iter_reg       <= '0;
            iv_pend_reg    <= 1'b0;
            rekey_done_reg <= 1'b0;
            make_ks_reg    <= 1'b0;
            mem_clr_reg    <= 1'b1;
            carry_reg      <= 1'b0;
            rd_vld_reg     <= 1'b0;
            sq_vld_reg     <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (cfg_we) begin
                unique case (cfg_idx_t'(cfg_index))
                    CFG_KEY_LOW:  key_low_reg  <= cfg_data;
                    CFG_KEY_HIGH: key_high_reg <= cfg_data;
                    CFG_IV:       iv_reg       <= cfg_data;
                    CFG_USE_IV:   use_iv_reg   <= cfg_data[0];
                    default: ;
                endcase
            end
            if (out_fire) begin
                m_valid_reg <= 1'b0;
            end
            rd_vld_reg <= 1'b0;
            sq_vld_reg <= 1'b0;
            unique case (state_reg)
                ST_IDLE: begin
                    idx_reg <= '0;
                    if (in_fire) begin
                        data_reg <= s_data_byte;
                        last_reg <= s_last_of_call;
                        if (s_mode) begin
                            iter_reg       <= 4'd4;
                            rekey_done_reg <= 1'b0;
                            iv_pend_reg    <= 1'b0;
                            make_ks_reg    <= 1'b0;
                            carry_reg      <= 1'b0;
                            pos_reg        <= 5'd16;
                        end else if (pos_reg[4]) begin
                            iter_reg    <= 4'd1;
                            make_ks_reg <= 1'b1;
                        end
                    end
                end
                ST_LOAD: begin
                    idx_reg <= idx_reg[3] ? 4'd0 : idx_reg + 4'd1;
                    if (idx_reg[3]) begin
                        mem_clr_reg <= 1'b0;
                    end
                end
                ST_CTR: begin
                    if (!idx_reg[3]) begin
                        idx_reg    <= idx_reg + 4'd1;
                        rd_vld_reg <= 1'b1;
                        rd_idx_reg <= idx_reg[2:0];
                    end else if (!rd_vld_reg) begin
                        idx_reg <= '0;
                    end
                    if (rd_vld_reg) begin
                        carry_reg <= ctr_sum[32];
                    end
                end
                ST_GRD: begin
                    if (!idx_reg[3]) begin
                        idx_reg    <= idx_reg + 4'd1;
                        rd_vld_reg <= 1'b1;
                        rd_idx_reg <= idx_reg[2:0];
                    end
                    if (rd_vld_reg) begin
                        sq_reg     <= sq_comb;
                        sq_vld_reg <= 1'b1;
                        sq_idx_reg <= rd_idx_reg;
                    end
                    if (sq_vld_reg) begin
                        g_reg[sq_idx_reg] <= sq_reg[31:0] ^ sq_reg[63:32];
                    end
                    if (idx_reg[3] && !rd_vld_reg && !sq_vld_reg) begin
                        idx_reg <= '0;
                    end
                end
                ST_GMUL: begin
                end
                ST_WB: begin
                    if (!idx_reg[3]) begin
                        idx_reg <= idx_reg + 4'd1;
                    end else begin
                        idx_reg  <= '0;
                        iter_reg <= iter_reg - 4'd1;
                        if (iter_reg == 4'd1 && !make_ks_reg && rekey_done_reg) begin
                            iv_pend_reg <= 1'b0;
                        end
                    end
                end
                ST_REKEY: begin
                    if (!idx_reg[3]) begin
                        idx_reg    <= idx_reg + 4'd1;
                        rd_vld_reg <= 1'b1;
                        rd_idx_reg <= idx_reg[2:0];
                    end else if (!rd_vld_reg) begin
                        idx_reg <= '0;
                        if (!rekey_done_reg) begin
                            rekey_done_reg <= 1'b1;
                            iv_pend_reg    <= use_iv_reg;
                            iter_reg       <= 4'd4;
                        end
                    end
                end
                ST_KS: begin
                    if (!idx_reg[3]) begin
                        idx_reg    <= idx_reg + 4'd1;
                        rd_vld_reg <= 1'b1;
                        rd_idx_reg <= idx_reg[2:0];
                    end
                    if (rd_vld_reg) begin
                        xs[rd_idx_reg] <= x_rd;
                    end
                    if (idx_reg[3] && !rd_vld_reg) begin
                        make_ks_reg <= 1'b0;
                        pos_reg     <= 5'd0;
                        for (int b = 0; b < 4; b++) begin
                            ks_reg[b]      <= s0[8*b +: 8];
                            ks_reg[4 + b]  <= s1[8*b +: 8];
                            ks_reg[8 + b]  <= s2[8*b +: 8];
                            ks_reg[12 + b] <= s3[8*b +: 8];
                        end
                    end
                end
                ST_OUT: begin
                    out_reg     <= data_reg ^ ks_reg[pos_reg[3:0]];
                    m_valid_reg <= 1'b1;
                    pos_reg     <= last_reg ? 5'd16 : pos_reg + 5'd1;
                end
                default: begin
                end
            endcase
        end
    end

    // Stored words of the keystream extraction.
    // (xs is written in ST_KS above; declared as registers.)

    a_no_accept_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg != ST_IDLE) |-> !s_ready)
        else $error("input accepted while busy");

    a_out_after_out_state: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_OUT) |=> m_valid)
        else $error("no result after output state");

    a_pos_range: assert property (@(posedge aclk) disable iff (!aresetn)
        pos_reg <= 5'd16)
        else $error("block position out of range");

    a_ks_fills_block: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_OUT) |-> !pos_reg[4])
        else $error("byte taken from empty block");

endmodule
